@@ design/cdf_pkg.sv @@
// Shared types, constants and helpers for the calendar date facts pipeline.
// No dependencies; every other design file refers to this package by scoped names.
package cdf_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    CDF_OK           = 3'd0,
    CDF_BAD_YEAR     = 3'd1,
    CDF_BAD_MONTH    = 3'd2,
    CDF_BAD_DAY      = 3'd3,
    CDF_DAY_PAST_END = 3'd4
  } cdf_status_e;

  localparam logic [6:0] LastYear   = 7'd99;
  localparam logic [3:0] LastMonth  = 4'd12;
  localparam logic [3:0] February   = 4'd2;
  localparam logic [8:0] CommonYear = 9'd365;
  localparam logic [8:0] LeapYear   = 9'd366;
  // 2000-01-01 was a Saturday: Monday-zero weekday 5.
  localparam logic [2:0] Jan1Offset = 3'd5;
  localparam logic [2:0] Sunday0    = 3'd6;

  typedef struct packed {
    logic [5:0] q;
    logic [2:0] r;
  } cdf_divmod_t;

  // Stage 1 -> stage 2.
  typedef struct packed {
    cdf_status_e status;
    logic        leap;
    logic [4:0]  mlen;
    logic [8:0]  days_prior;
    logic [8:0]  doy;
    logic [2:0]  jan1;
  } cdf_s1_t;

  // Stage 2 -> stage 3.
  typedef struct packed {
    cdf_status_e status;
    logic        leap;
    logic [4:0]  mlen;
    logic [8:0]  doy;
    logic [2:0]  jan1;
    logic [2:0]  wd0;
    logic [2:0]  fwd0;
    logic [2:0]  dec0;
  } cdf_s2_t;

  // Divide by 7 for v up to 372: reciprocal multiply that never overshoots,
  // then one correction step.
  function automatic cdf_divmod_t cdf_divmod7(input logic [8:0] v);
    logic [14:0] prod;
    logic [5:0]  q0;
    logic [8:0]  r0;
    cdf_divmod_t res;
    prod = {6'd0, v} * 15'd36;
    q0   = prod[13:8];
    r0   = v - ({3'd0, q0} * 9'd7);
    if (r0 >= 9'd7) begin
      res.q = q0 + 6'd1;
      res.r = 3'(r0 - 9'd7);
    end else begin
      res.q = q0;
      res.r = r0[2:0];
    end
    return res;
  endfunction

  function automatic logic [4:0] cdf_month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [8:0] cdf_month_start(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ design/cdf_if.sv @@
// Valid/ready channel interfaces for date beats in and fact beats out.
// Depends on cdf_pkg for the status type.
interface cdf_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] year;
  logic [3:0] month;
  logic [4:0] day;

  modport source (output valid, output year, output month, output day, input ready);
  modport sink (input valid, input year, input month, input day, output ready);
endinterface

interface cdf_out_if;
  logic               valid;
  logic               ready;
  cdf_pkg::cdf_status_e status;
  logic [2:0]         weekday;
  logic [2:0]         first_weekday;
  logic [4:0]         month_length;
  logic [8:0]         year_length;
  logic [8:0]         day_of_year;
  logic [5:0]         week_of_year;
  logic               first_week_number;
  logic [5:0]         last_week_number;

  modport source (
    output valid, output status, output weekday, output first_weekday,
    output month_length, output year_length, output day_of_year,
    output week_of_year, output first_week_number, output last_week_number,
    input ready
  );
  modport sink (
    input valid, input status, input weekday, input first_weekday,
    input month_length, input year_length, input day_of_year,
    input week_of_year, input first_week_number, input last_week_number,
    output ready
  );
endinterface

@@ design/calendar_date_facts.sv @@
// Top level: three-stage pipeline turning a date of 2000..2099 into calendar facts.
// Depends on cdf_pkg and the channel interfaces in cdf_if.sv.
//
//   channel  dir  beat contents
//   in_i     in   year, month, day
//   out_o    out  status and eight date facts
//
// Beats pass s1_q, s2_q and the output register; one per cycle unless out_o stalls.
// Stage 1 checks and looks up month tables, stage 2 reduces weekdays mod 7,
// stage 3 divides for week numbers and holds the output register.
// Reset clears only the stage valid bits. A stall on out_o backs up stage by
// stage; a stage with a free slot keeps accepting, so nothing is lost or repeated.
module calendar_date_facts (
  input  logic             clk_i,
  input  logic             rst_ni,
  cdf_in_if.sink           in_i,
  cdf_out_if.source        out_o
);

  logic v1_q, v2_q, v3_q;
  logic ready1, ready2, ready3;

  cdf_pkg::cdf_s1_t s1_d, s1_q;
  cdf_pkg::cdf_s2_t s2_d, s2_q;

  // Output register payload.
  cdf_pkg::cdf_status_e status_d, status_q;
  logic [2:0] weekday_d, weekday_q, first_weekday_d, first_weekday_q;
  logic [4:0] month_length_d, month_length_q;
  logic [8:0] year_length_d, year_length_q, day_of_year_d, day_of_year_q;
  logic [5:0] week_of_year_d, week_of_year_q, last_week_d, last_week_q;
  logic       first_week_d, first_week_q;

  assign ready3     = !v3_q || out_o.ready;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_i.ready = ready1;

  // Stage 1: checks, leap, month tables, ordinal day, January 1 weekday.
  logic       leap1;
  logic [4:0] mlen1;
  logic [8:0] before1;
  logic [8:0] jan_sum1;

  always_comb begin
    leap1    = (in_i.year[1:0] == 2'b00);
    mlen1    = cdf_pkg::cdf_month_days(in_i.month, leap1);
    before1  = cdf_pkg::cdf_month_start(in_i.month)
             + {8'd0, leap1 && (in_i.month > cdf_pkg::February)};
    jan_sum1 = {2'b00, in_i.year} + {4'd0, 5'((in_i.year + 7'd3) >> 2)}
             + {6'd0, cdf_pkg::Jan1Offset};

    s1_d.leap       = leap1;
    s1_d.mlen       = mlen1;
    s1_d.days_prior = before1;
    s1_d.doy        = before1 + {4'd0, in_i.day};
    s1_d.jan1       = cdf_pkg::cdf_divmod7(jan_sum1).r;

    if (in_i.year > cdf_pkg::LastYear) begin
      s1_d.status = cdf_pkg::CDF_BAD_YEAR;
    end else if (in_i.month == 4'd0 || in_i.month > cdf_pkg::LastMonth) begin
      s1_d.status = cdf_pkg::CDF_BAD_MONTH;
    end else if (in_i.day == 5'd0) begin
      s1_d.status = cdf_pkg::CDF_BAD_DAY;
    end else if (in_i.day > mlen1) begin
      s1_d.status = cdf_pkg::CDF_DAY_PAST_END;
    end else begin
      s1_d.status = cdf_pkg::CDF_OK;
    end
  end

  // Stage 2: weekday of the date, of the first of the month, of December 31.
  always_comb begin
    s2_d.status = s1_q.status;
    s2_d.leap   = s1_q.leap;
    s2_d.mlen   = s1_q.mlen;
    s2_d.doy    = s1_q.doy;
    s2_d.jan1   = s1_q.jan1;
    s2_d.wd0    = cdf_pkg::cdf_divmod7({6'd0, s1_q.jan1} + s1_q.doy - 9'd1).r;
    s2_d.fwd0   = cdf_pkg::cdf_divmod7({6'd0, s1_q.jan1} + s1_q.days_prior).r;
    // 364 days is whole weeks: Dec 31 falls on Jan 1's weekday, plus one if leap.
    if (!s1_q.leap) begin
      s2_d.dec0 = s1_q.jan1;
    end else if (s1_q.jan1 == cdf_pkg::Sunday0) begin
      s2_d.dec0 = 3'd0;
    end else begin
      s2_d.dec0 = s1_q.jan1 + 3'd1;
    end
  end

  // Stage 3: week numbers; zero every fact on error.
  logic [8:0] ylen3;

  always_comb begin
    ylen3    = s2_q.leap ? cdf_pkg::LeapYear : cdf_pkg::CommonYear;
    status_d = s2_q.status;
    if (s2_q.status == cdf_pkg::CDF_OK) begin
      weekday_d       = s2_q.wd0 + 3'd1;
      first_weekday_d = s2_q.fwd0 + 3'd1;
      month_length_d  = s2_q.mlen;
      year_length_d   = ylen3;
      day_of_year_d   = s2_q.doy;
      week_of_year_d  = cdf_pkg::cdf_divmod7(s2_q.doy + 9'd6 - {6'd0, s2_q.wd0}).q;
      first_week_d    = (s2_q.jan1 == 3'd0);
      last_week_d     = cdf_pkg::cdf_divmod7(ylen3 + 9'd6 - {6'd0, s2_q.dec0}).q;
    end else begin
      weekday_d       = '0;
      first_weekday_d = '0;
      month_length_d  = '0;
      year_length_d   = '0;
      day_of_year_d   = '0;
      week_of_year_d  = '0;
      first_week_d    = 1'b0;
      last_week_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_i.valid;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && in_i.valid) s1_q <= s1_d;
    if (ready2 && v1_q) s2_q <= s2_d;
    if (ready3 && v2_q) begin
      status_q        <= status_d;
      weekday_q       <= weekday_d;
      first_weekday_q <= first_weekday_d;
      month_length_q  <= month_length_d;
      year_length_q   <= year_length_d;
      day_of_year_q   <= day_of_year_d;
      week_of_year_q  <= week_of_year_d;
      first_week_q    <= first_week_d;
      last_week_q     <= last_week_d;
    end
  end

  assign out_o.valid             = v3_q;
  assign out_o.status            = status_q;
  assign out_o.weekday           = weekday_q;
  assign out_o.first_weekday     = first_weekday_q;
  assign out_o.month_length      = month_length_q;
  assign out_o.year_length       = year_length_q;
  assign out_o.day_of_year       = day_of_year_q;
  assign out_o.week_of_year      = week_of_year_q;
  assign out_o.first_week_number = first_week_q;
  assign out_o.last_week_number  = last_week_q;

endmodule

@@ design/cdf_checker.sv @@
// Port-level checks for calendar_date_facts, attached with a bind.
// Depends on cdf_pkg for status codes.
module cdf_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input cdf_pkg::cdf_status_e status_i,
  input logic [2:0]           weekday_i,
  input logic [8:0]           year_length_i,
  input logic [8:0]           day_of_year_i,
  input logic [5:0]           last_week_i
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(day_of_year_i))
    else $error("stalled result beat changed");

  // Errors zero the facts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != cdf_pkg::CDF_OK |->
      weekday_i == 3'd0 && day_of_year_i == 9'd0 && last_week_i == 6'd0)
    else $error("error beat carries nonzero facts");

  // Good dates stay within their year.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == cdf_pkg::CDF_OK |->
      weekday_i != 3'd0 && day_of_year_i != 9'd0 && day_of_year_i <= year_length_i
      && (year_length_i == 9'd365 || year_length_i == 9'd366))
    else $error("good beat out of range");

  // An accepted beat reaches the output when the output side keeps taking beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("accepted beat did not reach the output in three cycles");

endmodule

bind calendar_date_facts cdf_checker u_cdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .weekday_i     (out_o.weekday),
  .year_length_i (out_o.year_length),
  .day_of_year_i (out_o.day_of_year),
  .last_week_i   (out_o.last_week_number)
);

@@ verif/calendar_date_facts_tb.sv @@
// Self-checking testbench for calendar_date_facts: sends date beats and checks every
// fact beat against an in-bench calendar predictor. Depends on cdf_pkg and cdf_if.sv.
`timescale 1ns / 100ps

module calendar_date_facts_tb;

  localparam int unsigned StallLimit = 1000;

  typedef struct packed {
    cdf_pkg::cdf_status_e status;
    logic [2:0]  weekday;
    logic [2:0]  first_weekday;
    logic [4:0]  month_length;
    logic [8:0]  year_length;
    logic [8:0]  day_of_year;
    logic [5:0]  week_of_year;
    logic        first_week_number;
    logic [5:0]  last_week_number;
  } date_facts_t;

  logic clk;
  logic rst_n;

  cdf_in_if  date_ch ();
  cdf_out_if facts_ch ();

  calendar_date_facts i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (date_ch),
    .out_o (facts_ch)
  );

  date_facts_t facts_due[$];
  int unsigned dates_sent;
  int unsigned beats_checked;
  int unsigned mismatches;
  int unsigned status_seen[5];
  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned sink_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap_year(logic [6:0] yr);
    int unsigned full;
    full = 2000 + yr;
    return (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(logic [3:0] mon, bit leap);
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
      4'd2:                                       return leap ? 29 : 28;
      default:                                    return 0;
    endcase
  endfunction

  // Monday 1 .. Sunday 7, counted from 2000-01-01, a Saturday.
  function automatic int unsigned weekday_of(int unsigned days);
    return ((days + 5) % 7) + 1;
  endfunction

  // Monday-based week number as strftime %W counts it.
  function automatic int unsigned monday_week(int unsigned doy, int unsigned wd);
    return (doy + 7 - wd) / 7;
  endfunction

  function automatic date_facts_t date_facts(logic [6:0] yr, logic [3:0] mon, logic [4:0] dy);
    date_facts_t f;
    bit          leap;
    int unsigned mlen, ylen, prior_days, doy, base, wd;
    f = '0;
    if (yr > 7'd99) begin
      f.status = cdf_pkg::CDF_BAD_YEAR;
    end else if (mon < 4'd1 || mon > 4'd12) begin
      f.status = cdf_pkg::CDF_BAD_MONTH;
    end else if (dy < 5'd1) begin
      f.status = cdf_pkg::CDF_BAD_DAY;
    end else begin
      leap = is_leap_year(yr);
      mlen = days_in_month(mon, leap);
      if (dy > mlen) begin
        f.status = cdf_pkg::CDF_DAY_PAST_END;
      end else begin
        ylen       = leap ? 366 : 365;
        prior_days = 0;
        for (int m = 1; m < mon; m++) prior_days += days_in_month(4'(m), leap);
        doy  = prior_days + dy;
        base = 365 * yr + (yr + 3) / 4;
        wd   = weekday_of(base + doy - 1);
        f.status            = cdf_pkg::CDF_OK;
        f.weekday           = 3'(wd);
        f.first_weekday     = 3'(weekday_of(base + prior_days));
        f.month_length      = 5'(mlen);
        f.year_length       = 9'(ylen);
        f.day_of_year       = 9'(doy);
        f.week_of_year      = 6'(monday_week(doy, wd));
        f.first_week_number = 1'(monday_week(1, weekday_of(base)));
        f.last_week_number  = 6'(monday_week(ylen, weekday_of(base + ylen - 1)));
      end
    end
    return f;
  endfunction

  // Offer one date beat; keep valid high afterwards so back-to-back beats need no toggle.
  task automatic send_date(logic [6:0] yr, logic [3:0] mon, logic [4:0] dy);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      date_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    date_ch.valid <= 1'b1;
    date_ch.year  <= yr;
    date_ch.month <= mon;
    date_ch.day   <= dy;
    do @(posedge clk); while (!date_ch.ready);
    facts_due.push_back(date_facts(yr, mon, dy));
    dates_sent++;
  endtask

  task automatic release_input();
    date_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    while (facts_due.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed dates, some just past the month end, the rest raw noise.
  task automatic send_random_date();
    logic [6:0]  yr;
    logic [3:0]  mon;
    logic [4:0]  dy;
    int unsigned mlen;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    yr   = 7'($urandom_range(0, 99));
    mon  = 4'($urandom_range(1, 12));
    mlen = days_in_month(mon, is_leap_year(yr));
    if (pick < 75) begin
      dy = 5'($urandom_range(1, mlen));
    end else if (pick < 82 && mlen < 31) begin
      dy = 5'($urandom_range(mlen + 1, 31));
    end else begin
      yr  = 7'($urandom_range(0, 127));
      mon = 4'($urandom_range(0, 15));
      dy  = 5'($urandom_range(0, 31));
    end
    send_date(yr, mon, dy);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic test_directed_dates();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_date(7'd0, 4'd1, 5'd1);     // epoch, a Saturday
    send_date(7'd99, 4'd12, 5'd31);
    send_date(7'd0, 4'd12, 5'd31);   // day 366
    send_date(7'd1, 4'd1, 5'd1);     // year opens on a Monday
    send_date(7'd12, 4'd1, 5'd1);    // year opens on a Sunday
    send_date(7'd12, 4'd12, 5'd31);  // week 53
    send_date(7'd0, 4'd2, 5'd29);
    send_date(7'd4, 4'd2, 5'd29);
    send_date(7'd0, 4'd3, 5'd1);
    send_date(7'd1, 4'd3, 5'd1);
    send_date(7'd99, 4'd11, 5'd30);
    send_date(7'd63, 4'd7, 5'd31);
    send_date(7'd1, 4'd2, 5'd29);    // past end of a common February
    send_date(7'd4, 4'd2, 5'd30);    // past end of a leap February
    send_date(7'd5, 4'd4, 5'd31);
    send_date(7'd99, 4'd11, 5'd31);
    send_date(7'd100, 4'd1, 5'd1);
    send_date(7'd127, 4'd15, 5'd31);
    send_date(7'd127, 4'd0, 5'd0);   // year is checked before month and day
    send_date(7'd99, 4'd0, 5'd1);
    send_date(7'd50, 4'd13, 5'd10);
    send_date(7'd0, 4'd0, 5'd0);     // month is checked before day
    send_date(7'd50, 4'd6, 5'd0);
    send_date(7'd0, 4'd12, 5'd0);
  endtask

  task automatic test_random_dates();
    for (int seg = 0; seg < 9; seg++) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      repeat (100) send_random_date();
    end
  endtask

  // Hold the output long enough for the pipeline to fill and stall the input.
  task automatic test_output_hold();
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    sink_hold_req = 150;
    repeat (40) send_random_date();
    release_input();
    wait_for_drain();
  endtask

  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (300) send_random_date();
    release_input();
  endtask

  initial begin : date_stimulus
    rst_n          = 1'b0;
    date_ch.valid <= 1'b0;
    date_ch.year  <= '0;
    date_ch.month <= '0;
    date_ch.day   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_dates();
    test_random_dates();
    test_output_hold();
    test_full_rate();

    wait_for_drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d dates and checked %0d fact beats, incl. leap years, week 53 and stalls.",
             dates_sent, beats_checked);
    $display("Status mix ok/year/month/day/past-end: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("** calendar_date_facts: PASSED **");
    end else begin
      $display("** calendar_date_facts: FAILED **");
    end
    $finish;
  end

  initial begin : fact_sink
    int unsigned stall_left;
    int unsigned hold_left;
    date_facts_t got;
    date_facts_t want;
    stall_left      = 0;
    hold_left       = 0;
    facts_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (facts_ch.valid && facts_ch.ready) begin
        got.status            = facts_ch.status;
        got.weekday           = facts_ch.weekday;
        got.first_weekday     = facts_ch.first_weekday;
        got.month_length      = facts_ch.month_length;
        got.year_length       = facts_ch.year_length;
        got.day_of_year       = facts_ch.day_of_year;
        got.week_of_year      = facts_ch.week_of_year;
        got.first_week_number = facts_ch.first_week_number;
        got.last_week_number  = facts_ch.last_week_number;
        beats_checked++;
        if (facts_due.size() == 0) begin
          $error("fact beat with no date pending (status %0d)", got.status);
          mismatches++;
        end else begin
          want = facts_due.pop_front();
          if (want.status <= cdf_pkg::CDF_DAY_PAST_END) status_seen[want.status]++;
          check_field("status", want.status, got.status);
          check_field("weekday", want.weekday, got.weekday);
          check_field("first_weekday", want.first_weekday, got.first_weekday);
          check_field("month_length", want.month_length, got.month_length);
          check_field("year_length", want.year_length, got.year_length);
          check_field("day_of_year", want.day_of_year, got.day_of_year);
          check_field("week_of_year", want.week_of_year, got.week_of_year);
          check_field("first_week_number", want.first_week_number, got.first_week_number);
          check_field("last_week_number", want.last_week_number, got.last_week_number);
        end
      end
      if (sink_hold_req > 0) begin
        hold_left     = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        facts_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        facts_ch.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left      = $urandom_range(1, 13) - 1;
        facts_ch.ready <= 1'b0;
      end else begin
        facts_ch.ready <= 1'b1;
      end
    end
  end

  // Count cycles in which neither channel moves a beat.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((date_ch.valid && date_ch.ready) || (facts_ch.valid && facts_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no beat moved for %0d cycles, %0d results pending",
             StallLimit, facts_due.size());
    $display("** calendar_date_facts: FAILED **");
    $finish;
  end

endmodule
